// File: rtl/bfsha_pkg.sv
// Package for the Bloom filter SHA-256 key check.
// Holds widths, register indexes, the sequencer states and SHA-256 constants.
// No dependencies.
package bfsha_pkg;

   localparam int MaxFilterBytes = 16;
   localparam int MaxSaltBytes   = 8;
   localparam int KeyBytes       = 16;

   localparam logic [2:0] CSR_FILTER_LOW  = 3'd0;
   localparam logic [2:0] CSR_FILTER_HIGH = 3'd1;
   localparam logic [2:0] CSR_FILTER_LEN  = 3'd2;
   localparam logic [2:0] CSR_SALT        = 3'd3;
   localparam logic [2:0] CSR_SALT_LEN    = 3'd4;

   localparam logic [7:0] ALT_FIRST_A = 8'h05;
   localparam logic [7:0] ALT_FIRST_B = 8'h06;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_FINAL,
      ST_MOD,
      ST_TEST,
      ST_DONE
   } state_type;

   // Control from the sequencer to the hash core.
   typedef struct packed {
      logic load;   // load IV and message block
      logic round;  // run one compression round
      logic final_add; // add IV into working variables
   } hash_ctrl_type;

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

// File: rtl/bfsha_core.sv
// Iterative SHA-256 compression: one round per cycle, 16-word schedule window.
// Depends on bfsha_pkg.
module bfsha_core
   import bfsha_pkg::*;
(
   input  logic          clock,
   input  hash_ctrl_type ctrl,
   input  logic [5:0]    round_idx,
   input  logic [511:0]  block,
   output logic [255:0]  digest
);

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] s0, s1, wnew, e1, ch, t1, a0, mj, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      e1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + e1 + ch + sha_k(round_idx) + w_ff[0];
      a0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = a0 + mj;
      v_in = v_ff;
      w_in = w_ff;
      if (ctrl.load) begin
         for (int i = 0; i < 8; i++) v_in[i] = SHA_IV[255 - 32*i -: 32];
         for (int i = 0; i < 16; i++) w_in[i] = block[511 - 32*i -: 32];
      end else if (ctrl.round) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wnew;
      end else if (ctrl.final_add) begin
         for (int i = 0; i < 8; i++) v_in[i] = v_ff[i] + SHA_IV[255 - 32*i -: 32];
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = v_ff[i];
   end

endmodule

// File: rtl/bfsha_mod.sv
// Bit-serial reduction of a 32-bit word modulo a bit count of 8..128.
// Depends on bfsha_pkg.
module bfsha_mod
   import bfsha_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] word,
   input  logic [7:0]  modulus,
   output logic [6:0]  remainder
);

   // One quotient bit per cycle; 32 steps after load.
   logic [31:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [8:0]  trial;

   always_comb begin
      trial = {r_ff, q_ff[31]};
      q_in  = {q_ff[30:0], 1'b0};
      r_in  = (trial >= {1'b0, modulus}) ? 8'(trial - {1'b0, modulus}) : trial[7:0];
      if (load) begin
         q_in = word;
         r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign remainder = r_ff[6:0];

endmodule

// File: rtl/bloom_filter_sha256_key_check.sv
// Top level of the Bloom filter key check.
// Depends on bfsha_pkg, bfsha_core and bfsha_mod.
//
// Usage: write the filter, its length and the salt through the csr_ port
// while the block is idle. Pulse start with a key on req_key_upper,
// req_key_lower and req_key_valid; the transfer is taken when busy is low.
// The answer is on rsp_possibly_present with the one-cycle rsp_strobe.
// The receiver cannot stall; busy stays high through the strobe cycle.
// An invalid key or zero filter length goes from the accept straight to
// ST_DONE and its strobe, with no hashing. Otherwise each of up to three
// key variants takes a load step, 64 compression rounds and a final add,
// then up to eight digest words, each reduced by a 32-step shift-subtract
// unit and tested; a clear filter bit ends that variant.
// Reset sets the sequencer state to ST_IDLE and all configuration
// registers to zero; the other sequencer registers are not reset.
// Filter length above 16 acts as 16, salt length above 8 acts as 8;
// writes to unknown register indexes are dropped.
module bloom_filter_sha256_key_check
   import bfsha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_key_upper,
   input  logic [63:0] req_key_lower,
   input  logic        req_key_valid,
   output logic        rsp_strobe,
   output logic        rsp_possibly_present,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] flo_ff, fhi_ff, salt_ff;
   logic [4:0]  flen_ff;
   logic [3:0]  slen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flo_ff <= '0; fhi_ff <= '0; salt_ff <= '0; flen_ff <= '0; slen_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FILTER_LOW:  flo_ff  <= csr_write_data;
            CSR_FILTER_HIGH: fhi_ff  <= csr_write_data;
            CSR_FILTER_LEN:  flen_ff <= csr_write_data[4:0];
            CSR_SALT:        salt_ff <= csr_write_data;
            CSR_SALT_LEN:    slen_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Effective lengths after saturation.
   logic [4:0] nbytes;
   logic [3:0] nsalt;
   assign nbytes = (flen_ff > 5'(MaxFilterBytes)) ? 5'(MaxFilterBytes) : flen_ff;
   assign nsalt  = (slen_ff > 4'(MaxSaltBytes)) ? 4'(MaxSaltBytes) : slen_ff;

   // Key and sequencer registers.
   state_type   state_ff, state_in;
   logic [127:0] key_ff, key_in;
   logic        kvalid_ff, kvalid_in;
   logic [1:0]  variant_ff, variant_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  word_ff, word_in;
   logic        hit_ff, hit_in;
   logic        out_ff, out_in;
   hash_ctrl_type ctrl;
   logic        mod_load;

   // Message block: key, salt, 0x80 pad, bit length.
   logic [511:0] block;
   logic [7:0]   first_byte;
   logic [7:0]   msg_len;
   always_comb begin
      unique case (variant_ff)
         2'd1:    first_byte = ALT_FIRST_A;
         2'd2:    first_byte = ALT_FIRST_B;
         default: first_byte = key_ff[127:120];
      endcase
      block = '0;
      block[511 -: 128] = {first_byte, key_ff[119:0]};
      for (int i = 0; i < MaxSaltBytes; i++) begin
         if (4'(i) < nsalt) block[383 - 8*i -: 8] = salt_ff[8*i +: 8];
      end
      for (int i = 0; i <= MaxSaltBytes; i++) begin
         if (4'(i) == nsalt) block[383 - 8*i -: 8] = 8'h80;
      end
      msg_len = 8'(KeyBytes) + {4'b0, nsalt};
      block[15:0] = {5'b0, msg_len, 3'b0};
   end

   logic [255:0] digest;
   logic [6:0]   rem;
   logic [31:0]  sel_word;
   logic [127:0] fbits;
   logic         bit_set;

   assign sel_word = digest[255 - 32*word_ff -: 32];
   assign fbits    = {fhi_ff, flo_ff};
   assign bit_set  = fbits[rem];

   bfsha_core u_core (
      .clock     (clock),
      .ctrl      (ctrl),
      .round_idx (cnt_ff),
      .block     (block),
      .digest    (digest)
   );

   bfsha_mod u_mod (
      .clock     (clock),
      .load      (mod_load),
      .word      (sel_word),
      .modulus   ({nbytes, 3'b0}),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff     <= key_in;
      kvalid_ff  <= kvalid_in;
      variant_ff <= variant_in;
      cnt_ff     <= cnt_in;
      word_ff    <= word_in;
      hit_ff     <= hit_in;
      out_ff     <= out_in;
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      kvalid_in  = kvalid_ff;
      variant_in = variant_ff;
      cnt_in     = cnt_ff;
      word_in    = word_ff;
      hit_in     = hit_ff;
      out_in     = out_ff;
      ctrl       = '0;
      mod_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in     = {req_key_upper, req_key_lower};
               kvalid_in  = req_key_valid;
               variant_in = 2'd0;
               out_in     = 1'b0;
               // Load happens next cycle from the registered key.
               state_in   = (req_key_valid && nbytes != 5'd0) ? ST_FINAL : ST_DONE;
               cnt_in     = '0;
               hit_in     = 1'b0;
            end
         end
         ST_FINAL: begin
            // Dual use: entry when hit_ff is low loads the block; when high, final add.
            if (!hit_ff) begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               state_in  = ST_HASH;
            end else begin
               ctrl.final_add = 1'b1;
               word_in  = '0;
               state_in = ST_MOD;
               hit_in   = 1'b1;
            end
         end
         ST_HASH: begin
            ctrl.round = 1'b1;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_FINAL;
               hit_in   = 1'b1;
            end
         end
         ST_MOD: begin
            mod_load = 1'b1;
            cnt_in   = '0;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               if (!bit_set) begin
                  hit_in = 1'b0;
                  if (variant_ff == 2'd2) begin
                     state_in = ST_DONE;
                  end else begin
                     variant_in = variant_ff + 2'd1;
                     state_in   = ST_FINAL;
                  end
               end else if (word_ff == 3'd7) begin
                  out_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  word_in  = word_ff + 3'd1;
                  state_in = ST_MOD;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = (state_ff == ST_DONE);
   assign rsp_possibly_present = out_ff & kvalid_ff;

endmodule
